### hdl/pas_pkg.sv
// Shared types and constants for the positional array store.
`timescale 1ns / 1ps

package pas_pkg;

  localparam int DEPTH        = 32;
  localparam int RESULT_LIMIT = 32;
  // largest number of entries the list can ever hold
  localparam int CAP_MAX      = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(CAP_MAX + 1);

  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CAP_W        = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_TRAVERSE = 2'd0,
    OP_INSERT   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_SEARCH   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_BAD,
    RES_HIT,
    RES_MISS,
    RES_ELEM,
    RES_EMPTY
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_STEP,
    ST_INS_MOVE,
    ST_DEL_STEP,
    ST_DEL_MOVE,
    ST_SRC_STEP,
    ST_SRC_CMP,
    ST_TRV_READ,
    ST_TRV_EMIT,
    ST_REPLY_OK,
    ST_REPLY_BAD,
    ST_REPLY_MISS,
    ST_REPLY_EMPTY
  } state_t;

  typedef struct packed {
    logic      latch_in;
    logic      idx_clear;
    logic      idx_fill;
    logic      idx_pos;
    logic      idx_inc;
    logic      idx_dec;
    logic      rd_prev;
    logic      rd_next;
    logic      rd_cur;
    logic      wr_shift;
    logic      wr_new;
    logic      fill_inc;
    logic      fill_dec;
    logic      out_load;
    res_kind_t kind;
  } pas_cmd_t;

  typedef struct packed {
    op_t  op;
    logic fill_zero;
    logic ins_ok;
    logic del_ok;
    logic ins_end;
    logic del_end;
    logic scan_end;
    logic match;
    logic trav_last;
    logic out_free;
  } pas_stat_t;

endpackage

### hdl/pas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/pas_datapath.sv
// Datapath: element RAM, fill count, capacity register, scan index and result register.
`timescale 1ns / 1ps

module pas_datapath import pas_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pas_cmd_t                 cmd,
  output pas_stat_t                stat,
  input  logic [1:0]               in_op,
  input  logic [POS_W-1:0]         in_pos,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_cap,
  input  logic                     out_tready,
  output logic                     out_valid,
  output logic                     res_status,
  output logic                     res_found,
  output logic [5:0]               res_fpos,
  output logic signed [DATA_W-1:0] res_element,
  output logic                     res_element_valid,
  output logic [5:0]               res_count,
  output logic                     res_last
);

  op_t                     op_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CAP_W-1:0]        cap_r;
  logic [CAP_W-1:0]        cap_eff;
  logic                    out_valid_r, out_valid_nxt;

  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic [DATA_W-1:0]       wr_data;
  logic [DATA_W-1:0]       rd_data;
  logic                    rd_en;
  logic                    wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch_in) begin
      op_r  <= op_t'(in_op);
      pos_r <= in_pos;
      val_r <= in_value;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_inc) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.idx_fill) begin
      idx_nxt = fill_r;
    end else if (cmd.idx_pos) begin
      idx_nxt = CNT_W'(pos_r - POS_W'(1));
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - CNT_W'(1);
    end
  end

  assign cap_eff = (cap_r > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : cap_r;

  // moves read one neighbour of the index and write it back at the index
  always_comb begin
    if (cmd.rd_prev) begin
      rd_addr = ADDR_W'(idx_r - CNT_W'(1));
    end else if (cmd.rd_next) begin
      rd_addr = ADDR_W'(idx_r + CNT_W'(1));
    end else begin
      rd_addr = ADDR_W'(idx_r);
    end
  end

  assign rd_en   = cmd.rd_prev | cmd.rd_next | cmd.rd_cur;
  assign wr_en   = cmd.wr_shift | cmd.wr_new;
  assign wr_addr = ADDR_W'(idx_r);
  assign wr_data = cmd.wr_new ? val_r : rd_data;

  pas_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.op        = op_r;
    stat.fill_zero = (fill_r == '0);
    stat.ins_ok    = (pos_r != '0) && (7'(pos_r) <= 7'(fill_r) + 7'd1) &&
                     (CAP_W'(fill_r) < cap_eff);
    stat.del_ok    = (fill_r != '0) && (pos_r != '0) && (7'(pos_r) <= 7'(fill_r));
    stat.ins_end   = (7'(idx_r) == 7'(pos_r) - 7'd1);
    stat.del_end   = ((idx_r + CNT_W'(1)) == fill_r);
    stat.scan_end  = (idx_r == fill_r);
    stat.match     = (rd_data == val_r);
    stat.trav_last = ((idx_r + CNT_W'(1)) == fill_r);
    stat.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_status        <= 1'b0;
      res_found         <= 1'b0;
      res_fpos          <= '0;
      res_element       <= '0;
      res_element_valid <= 1'b0;
      res_count         <= 6'(fill_r);
      res_last          <= 1'b1;
      case (cmd.kind)
        RES_BAD: begin
          res_status <= 1'b1;
        end
        RES_HIT: begin
          res_found <= 1'b1;
          res_fpos  <= 6'(idx_r) + 6'd1;
        end
        RES_ELEM: begin
          res_element       <= rd_data;
          res_element_valid <= 1'b1;
          res_last          <= stat.trav_last;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/pas_ctrl.sv
// Controller: sequences insert, delete, search and traverse over the element RAM.
`timescale 1ns / 1ps

module pas_ctrl import pas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pas_stat_t stat,
  output pas_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.op)
          OP_TRAVERSE: begin
            if (stat.fill_zero) begin
              state_nxt = ST_REPLY_EMPTY;
            end else begin
              cmd.idx_clear = 1'b1;
              state_nxt     = ST_TRV_READ;
            end
          end
          OP_INSERT: begin
            if (!stat.ins_ok) begin
              state_nxt = ST_REPLY_BAD;
            end else begin
              cmd.idx_fill = 1'b1;
              state_nxt    = ST_INS_STEP;
            end
          end
          OP_DELETE: begin
            if (!stat.del_ok) begin
              state_nxt = ST_REPLY_BAD;
            end else begin
              cmd.idx_pos = 1'b1;
              state_nxt   = ST_DEL_STEP;
            end
          end
          default: begin
            cmd.idx_clear = 1'b1;
            state_nxt     = ST_SRC_STEP;
          end
        endcase
      end
      // insert walks down from the fill count, moving each entry up one
      ST_INS_STEP: begin
        if (stat.ins_end) begin
          cmd.wr_new   = 1'b1;
          cmd.fill_inc = 1'b1;
          state_nxt    = ST_REPLY_OK;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = ST_INS_MOVE;
        end
      end
      ST_INS_MOVE: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = ST_INS_STEP;
      end
      // delete walks up from the removed slot, moving each entry down one
      ST_DEL_STEP: begin
        if (stat.del_end) begin
          cmd.fill_dec = 1'b1;
          state_nxt    = ST_REPLY_OK;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = ST_DEL_MOVE;
        end
      end
      ST_DEL_MOVE: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = ST_DEL_STEP;
      end
      ST_SRC_STEP: begin
        if (stat.scan_end) begin
          state_nxt = ST_REPLY_MISS;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = ST_SRC_CMP;
        end
      end
      // read data holds, so a hit simply waits here for the result register
      ST_SRC_CMP: begin
        if (stat.match) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.kind     = RES_HIT;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SRC_STEP;
        end
      end
      ST_TRV_READ: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = ST_TRV_EMIT;
      end
      ST_TRV_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = RES_ELEM;
          if (stat.trav_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_TRV_READ;
          end
        end
      end
      ST_REPLY_OK: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = RES_OK;
          state_nxt    = ST_IDLE;
        end
      end
      ST_REPLY_BAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = RES_BAD;
          state_nxt    = ST_IDLE;
        end
      end
      ST_REPLY_MISS: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = RES_MISS;
          state_nxt    = ST_IDLE;
        end
      end
      ST_REPLY_EMPTY: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = RES_EMPTY;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/positional_array_store.sv
// Top level of the positional array store: ports, controller, datapath and checks.
`timescale 1ns / 1ps

// Ordered list of up to 32 signed 32-bit values in a single-port-per-side RAM,
// one command item at a time. Every RAM move needs a read and a write, so the
// controller spends a read state and a write state on each entry moved. Insert
// shifts entries from position p up one slot, delete shifts those above p down
// one, search compares entries in order until a hit, and traverse emits each
// element, waiting while the result channel stalls. A new item is taken as soon
// as the previous one has loaded its last result, even while that result still
// waits on out_tready. The RAM needs no clearing after reset: only entries below
// the fill count are ever read. The capacity register is written through cfg_*
// and should only change while the block is idle.
module positional_array_store import pas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // item in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] position, [37:6] data_value, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [0] status, [1] found, [7:2] found_position,
                                  // [39:8] element, [45:40] entry_count, [47:46] zero
  output logic        out_tuser,  // [0] element_valid
  output logic        out_tlast,
  // capacity register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  pas_cmd_t                 cmd;
  pas_stat_t                stat;
  logic                     res_status;
  logic                     res_found;
  logic [5:0]               res_fpos;
  logic signed [DATA_W-1:0] res_element;
  logic                     res_element_valid;
  logic [5:0]               res_count;
  logic                     res_last;

  assign cfg_ready = 1'b1;

  pas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pas_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_tuser),
    .in_pos            (in_tdata[5:0]),
    .in_value          (in_tdata[37:6]),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_cap           (cfg_data),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .res_status        (res_status),
    .res_found         (res_found),
    .res_fpos          (res_fpos),
    .res_element       (res_element),
    .res_element_valid (res_element_valid),
    .res_count         (res_count),
    .res_last          (res_last)
  );

  assign out_tdata = {2'b00, res_count, res_element, res_fpos, res_found, res_status};
  assign out_tuser = res_element_valid;
  assign out_tlast = res_last;

  // the result register is only loaded when empty or being emptied
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  // an accepted item keeps the input closed for at least the dispatch cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened straight after accept");

  // a shift write always follows the RAM read that fetched its data
  a_shift_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> $past(cmd.rd_prev || cmd.rd_next))
    else $error("shift write without a preceding read");

endmodule
